### sv/lge_pkg.sv
package lge_pkg;

    localparam int DEF_ROW_COUNT = 32;
    localparam int DEF_ROW_WIDTH = 32;

    localparam int OP_W        = 2;
    localparam int ROW_IDX_W   = 5;
    localparam int DATA_W      = 32;
    localparam int ROW_W_MAX   = 64;

    // B3/S23
    localparam logic [3:0] LIVE_BIRTH = 4'd3;
    localparam logic [3:0] LIVE_STAY  = 4'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctrl;

endpackage

### sv/lge_row_cell.sv
module lge_row_cell
    import lge_pkg::*;
#(
    parameter int ROW_WIDTH = DEF_ROW_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctrl           i_ctrl,
    input  logic [ROW_WIDTH-1:0] i_load_cells,
    input  logic [ROW_WIDTH-1:0] i_above,
    input  logic [ROW_WIDTH-1:0] i_below,
    output logic [ROW_WIDTH-1:0] o_cells
);

    logic [ROW_WIDTH-1:0] r_cells;
    logic [ROW_WIDTH-1:0] n_cells;
    logic [ROW_WIDTH-1:0] w_gen;

    // zero padding on both sides takes care of the board edges
    logic [ROW_WIDTH+1:0] w_up;
    logic [ROW_WIDTH+1:0] w_mid;
    logic [ROW_WIDTH+1:0] w_dn;

    assign w_up  = {1'b0, i_above, 1'b0};
    assign w_mid = {1'b0, r_cells, 1'b0};
    assign w_dn  = {1'b0, i_below, 1'b0};

    always_comb begin
        logic [3:0] cnt;
        for (int x = 0; x < ROW_WIDTH; x++) begin
            cnt = 4'(w_up[x]) + 4'(w_up[x+1]) + 4'(w_up[x+2])
                + 4'(w_mid[x]) + 4'(w_mid[x+2])
                + 4'(w_dn[x]) + 4'(w_dn[x+1]) + 4'(w_dn[x+2]);
            w_gen[x] = (cnt == LIVE_BIRTH) || (r_cells[x] && (cnt == LIVE_STAY));
        end
    end

    always_comb begin
        n_cells = r_cells;
        if (i_ctrl.load) begin
            n_cells = i_load_cells;
        end else if (i_ctrl.step) begin
            n_cells = w_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= '0;
        end else begin
            r_cells <= n_cells;
        end
    end

    assign o_cells = r_cells;

endmodule

### sv/life_generation_engine_top.sv
// Conway B3/S23 board of ROW_COUNT rows by ROW_WIDTH cells, no wrap-around.
// Each transaction loads a row, advances the board one generation or reads
// a row back; every transaction gives exactly one result (zero unless it is
// a read of a row on the board). One transaction per clock unless stalled:
// a chain of row cells, each holding one row and seeing its upper and lower
// neighbor, computes the full next generation combinationally. The result
// is registered in the cycle after acceptance; input is stalled only while
// that output register is full and the output side is stalling.
module life_generation_engine_top
    import lge_pkg::*;
#(
    parameter int ROW_COUNT = DEF_ROW_COUNT,
    parameter int ROW_WIDTH = DEF_ROW_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [ROW_IDX_W-1:0] i_row,
    input  logic [DATA_W-1:0]    i_row_cells,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_read_cells
);

    logic                 w_accept;
    logic [ROW_WIDTH-1:0] w_rows [ROW_COUNT];
    logic [ROW_WIDTH-1:0] w_load_cells;
    logic [ROW_WIDTH-1:0] w_sel_row;
    logic                 w_row_hit;
    logic [DATA_W-1:0]    w_answer;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [DATA_W-1:0]    r_read_cells;
    logic [DATA_W-1:0]    n_read_cells;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // bits past ROW_WIDTH are dropped, missing ones are dead
    assign w_load_cells = ROW_WIDTH'(ROW_W_MAX'(i_row_cells));

    for (genvar i = 0; i < ROW_COUNT; i++) begin : g_cell
        t_cell_ctrl           w_ctrl;
        logic [ROW_WIDTH-1:0] w_above;
        logic [ROW_WIDTH-1:0] w_below;

        assign w_ctrl.load = w_accept && (t_op'(i_op) == OP_LOAD) && (int'(i_row) == i);
        assign w_ctrl.step = w_accept && (t_op'(i_op) == OP_STEP);

        if (i == 0) begin : g_top
            assign w_above = '0;
        end else begin : g_mid_up
            assign w_above = w_rows[i-1];
        end
        if (i == ROW_COUNT - 1) begin : g_bot
            assign w_below = '0;
        end else begin : g_mid_dn
            assign w_below = w_rows[i+1];
        end

        lge_row_cell #(
            .ROW_WIDTH (ROW_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_load_cells (w_load_cells),
            .i_above      (w_above),
            .i_below      (w_below),
            .o_cells      (w_rows[i])
        );
    end

    always_comb begin
        w_sel_row = '0;
        w_row_hit = 1'b0;
        for (int i = 0; i < ROW_COUNT; i++) begin
            if (int'(i_row) == i) begin
                w_sel_row = w_rows[i];
                w_row_hit = 1'b1;
            end
        end
    end

    always_comb begin
        w_answer = '0;
        case (t_op'(i_op))
            OP_READ: begin
                if (w_row_hit) begin
                    w_answer = DATA_W'(ROW_W_MAX'(w_sel_row));
                end
            end
            default: w_answer = '0;
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_read_cells = r_read_cells;
        if (w_accept) begin
            n_out_valid  = 1'b1;
            n_read_cells = w_answer;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_read_cells <= n_read_cells;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_cells = r_read_cells;

    // only reads carry data
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_op'(i_op) != OP_READ)) |=> (o_read_cells == '0))
        else $error("non-read transaction produced nonzero data");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted transaction without result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

### test/life_generation_engine_checker.sv
`timescale 1ns / 100ps

module life_generation_engine_checker
    import lge_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [ROW_IDX_W-1:0] i_row,
    input  logic [DATA_W-1:0]    i_row_cells,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [DATA_W-1:0]    i_read_cells,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int ROWS = DEF_ROW_COUNT;
    localparam int COLS = DEF_ROW_WIDTH;

    logic [COLS-1:0]   board [ROWS];
    logic [DATA_W-1:0] read_cells_expected [$];
    logic [DATA_W-1:0] expected_cells;

    // All cells update from the old generation; off-board neighbors are dead.
    function automatic void advance_generation();
        logic [COLS-1:0] next_rows [ROWS];
        logic [COLS-1:0] above;
        logic [COLS-1:0] here;
        logic [COLS-1:0] below;
        int unsigned     count;
        for (int y = 0; y < ROWS; y++) begin
            above = (y > 0) ? board[y-1] : '0;
            here  = board[y];
            below = (y < ROWS - 1) ? board[y+1] : '0;
            for (int x = 0; x < COLS; x++) begin
                count = 0;
                for (int dx = -1; dx <= 1; dx++) begin
                    if (x + dx >= 0 && x + dx < COLS) begin
                        count += above[x+dx] + below[x+dx];
                        if (dx != 0)
                            count += here[x+dx];
                    end
                end
                if (here[x])
                    next_rows[y][x] = (count == LIVE_STAY || count == LIVE_BIRTH);
                else
                    next_rows[y][x] = (count == LIVE_BIRTH);
            end
        end
        board = next_rows;
    endfunction

    function automatic logic [DATA_W-1:0] apply_transaction(
        logic [OP_W-1:0]      op,
        logic [ROW_IDX_W-1:0] row,
        logic [DATA_W-1:0]    cells
    );
        logic [DATA_W-1:0] answer;
        answer = '0;
        case (op)
            OP_LOAD: begin
                if (row < ROWS)
                    board[row] = cells[COLS-1:0];
            end
            OP_STEP: advance_generation();
            OP_READ: begin
                if (row < ROWS)
                    answer = board[row];
            end
            default: ;
        endcase
        return answer;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (board[y])
                board[y] = '0;
            read_cells_expected.delete();
            o_pending <= 0;
        end else begin
            // retire before predicting: a result never belongs to the
            // transaction accepted at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (read_cells_expected.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result, read_cells %h",
                                 $time, i_read_cells);
                end else begin
                    expected_cells = read_cells_expected.pop_front();
                    if (i_read_cells !== expected_cells) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: read_cells expected %h, got %h",
                                     $time, expected_cells, i_read_cells);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                read_cells_expected.push_back(
                    apply_transaction(i_op, i_row, i_row_cells));
            o_pending <= read_cells_expected.size();
        end
    end

endmodule

### test/life_generation_engine_top_test.sv
`timescale 1ns / 100ps

module life_generation_engine_top_test;
    import lge_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1930;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op;
    logic [ROW_IDX_W-1:0] i_row;
    logic [DATA_W-1:0]    i_row_cells;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [DATA_W-1:0]    o_read_cells;

    int          fail_count;
    int          pending;
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;

    life_generation_engine_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_row        (i_row),
        .i_row_cells  (i_row_cells),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_cells (o_read_cells)
    );

    life_generation_engine_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_row        (i_row),
        .i_row_cells  (i_row_cells),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_read_cells (o_read_cells),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // output side: stall behavior switches among several patterns
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_mode  <= STALL_NONE;
            mode_left   <= 100;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                mode_left  <= $urandom_range(32, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 6);
                default:     i_out_stall <= ($urandom_range(0, 7) == 0) ? ~i_out_stall
                                                                      : i_out_stall;
            endcase
        end
    end

    // holds valid high across back-to-back transactions
    task automatic send_item(
        input logic [OP_W-1:0]      op,
        input logic [ROW_IDX_W-1:0] row,
        input logic [DATA_W-1:0]    cells
    );
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_row       <= row;
        i_row_cells <= cells;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    initial begin
        int                   sent;
        int                   burst;
        int                   pick;
        logic [OP_W-1:0]      op;
        logic [ROW_IDX_W-1:0] row;
        logic [DATA_W-1:0]    cells;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= OP_LOAD;
        i_row       <= '0;
        i_row_cells <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty board, field extremes, edges and corners
        send_item(OP_READ, 5'd0, 32'h0);
        send_item(OP_LOAD, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 5'd31, 32'h8000_0001);
        send_item(OP_READ, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_READ, 5'd31, 32'h0);
        send_item(OP_SPARE, 5'd5, 32'hFFFF_FFFF);
        send_item(OP_READ, 5'd5, 32'h0);
        send_item(OP_STEP, 5'd31, 32'hFFFF_FFFF);
        send_item(OP_READ, 5'd0, 32'h0);
        send_item(OP_READ, 5'd1, 32'h0);
        send_item(OP_READ, 5'd31, 32'h0);
        send_item(OP_READ, 5'd30, 32'h0);
        // blinkers against the low and high column edges
        send_item(OP_LOAD, 5'd15, 32'h0000_0007);
        send_item(OP_LOAD, 5'd16, 32'hE000_0000);
        send_item(OP_STEP, 5'd0, 32'h0);
        send_item(OP_READ, 5'd14, 32'h0);
        send_item(OP_READ, 5'd15, 32'h0);
        send_item(OP_READ, 5'd16, 32'h0);
        send_item(OP_STEP, 5'd0, 32'h0);
        send_item(OP_READ, 5'd15, 32'h0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    op = OP_LOAD;
                else if (pick < 45)
                    op = OP_STEP;
                else if (pick < 95)
                    op = OP_READ;
                else
                    op = OP_SPARE;
                row = ROW_IDX_W'($urandom_range(0, 31));
                case ($urandom_range(0, 4))
                    0:       cells = $urandom & $urandom;
                    1:       cells = $urandom | $urandom;
                    2:       cells = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    default: cells = $urandom;
                endcase
                send_item(op, row, cells);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### life_generation_engine_top.f
sv/lge_pkg.sv
sv/lge_row_cell.sv
sv/life_generation_engine_top.sv
test/life_generation_engine_checker.sv
test/life_generation_engine_top_test.sv
